>>> src/jsu_pkg.sv
// Package for the JSON string unescaper: status codes, the result bundle
// and the UTF-8 encoding constants. No dependencies.
package jsu_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned StatusW = 3;
  localparam int unsigned MaxBytes = 3;
  localparam int unsigned CntW = 2;

  // Status codes carried on every result beat
  localparam logic [StatusW-1:0] StRun     = 3'd0;
  localparam logic [StatusW-1:0] StDone    = 3'd1;
  localparam logic [StatusW-1:0] StNoQuote = 3'd2;
  localparam logic [StatusW-1:0] StBadEsc  = 3'd3;
  localparam logic [StatusW-1:0] StUnterm  = 3'd4;

  // UTF-8 lead/continuation markers and range limits
  localparam logic [ByteW-1:0] Utf8Lead2 = 8'hC0;
  localparam logic [ByteW-1:0] Utf8Lead3 = 8'hE0;
  localparam logic [ByteW-1:0] Utf8Cont  = 8'h80;
  localparam logic [ByteW-1:0] Utf8Mask6 = 8'h3F;
  localparam logic [15:0]      Cp1Limit  = 16'h0080;
  localparam logic [15:0]      Cp2Limit  = 16'h0800;

  // Decoded result of one input byte: 1 to 3 result beats
  typedef struct packed {
    logic [MaxBytes-1:0][ByteW-1:0] bytes;
    logic [CntW-1:0]                cnt;
    logic                           has_byte;
    logic [StatusW-1:0]             status;
  } res_t;

endpackage

>>> src/jsu_if.sv
// Valid/ready channel interfaces for the JSON string unescaper.
// Depends on jsu_pkg for field widths.
interface jsu_in_if import jsu_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface jsu_out_if import jsu_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ByteW-1:0]   out_byte;
  logic               has_byte;
  logic [StatusW-1:0] status;
  logic               last;

  modport source (output valid, output out_byte, output has_byte, output status,
                  output last, input ready);
  modport sink   (input valid, input out_byte, input has_byte, input status,
                  input last, output ready);
endinterface

>>> src/jsu_decode.sv
// Scanner state and per-byte decode: escapes, hex accumulation, UTF-8 encode.
// Depends on jsu_pkg.
module jsu_decode import jsu_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [ByteW-1:0] in_byte_i,
  output res_t             res_o
);

  localparam logic [2:0] MExpect = 3'd0;
  localparam logic [2:0] MBody   = 3'd1;
  localparam logic [2:0] MEsc    = 3'd2;
  localparam logic [2:0] MHex1   = 3'd3;
  localparam logic [2:0] MHex2   = 3'd4;
  localparam logic [2:0] MHex3   = 3'd5;
  localparam logic [2:0] MHex4   = 3'd6;

  logic [2:0]  mode_q, mode_d;
  logic [15:0] cp_q, cp_d;
  logic        bad_q, bad_d;

  logic [3:0]  hex_val;
  logic [15:0] cp_full;
  logic [CntW-1:0] n;
  logic [MaxBytes-1:0][ByteW-1:0] b;
  logic [StatusW-1:0] status;

  // Hex digit value; anything else counts as zero
  always_comb begin
    hex_val = 4'd0;
    if (in_byte_i >= "0" && in_byte_i <= "9") begin
      hex_val = 4'(in_byte_i - "0");
    end else if (in_byte_i >= "a" && in_byte_i <= "f") begin
      hex_val = 4'(in_byte_i - "a" + 8'd10);
    end else if (in_byte_i >= "A" && in_byte_i <= "F") begin
      hex_val = 4'(in_byte_i - "A" + 8'd10);
    end
  end

  assign cp_full = {cp_q[11:0], hex_val};

  // Next state and emitted bytes for the current byte
  always_comb begin
    mode_d = mode_q;
    cp_d   = cp_q;
    bad_d  = bad_q;
    n      = '0;
    b      = '0;
    status = StRun;
    unique case (mode_q)
      MBody: begin
        if (in_byte_i == 8'h00) begin
          status = StUnterm;
          mode_d = MExpect; cp_d = '0; bad_d = 1'b0;
        end else if (in_byte_i == "\"") begin
          status = bad_q ? StBadEsc : StDone;
          mode_d = MExpect; cp_d = '0; bad_d = 1'b0;
        end else if (in_byte_i == "\\") begin
          mode_d = MEsc;
        end else begin
          b[0] = in_byte_i; n = 2'd1;
        end
      end
      MEsc: begin
        mode_d = MBody;
        n      = 2'd1;
        unique case (in_byte_i)
          8'h00: begin
            status = StUnterm; n = '0;
            mode_d = MExpect; cp_d = '0; bad_d = 1'b0;
          end
          "n":  b[0] = 8'h0A;
          "r":  b[0] = 8'h0D;
          "t":  b[0] = 8'h09;
          "b":  b[0] = 8'h08;
          "f":  b[0] = 8'h0C;
          "\"": b[0] = "\"";
          "\\": b[0] = "\\";
          "/":  b[0] = "/";
          "u": begin
            n = '0; cp_d = '0; mode_d = MHex1;
          end
          default: begin
            n = '0; bad_d = 1'b1;
          end
        endcase
      end
      MHex1, MHex2, MHex3, MHex4: begin
        if (in_byte_i == 8'h00) begin
          status = StUnterm;
          mode_d = MExpect; cp_d = '0; bad_d = 1'b0;
        end else if (mode_q == MHex4) begin
          cp_d   = '0;
          mode_d = MBody;
          // UTF-8 encode of the completed code point
          if (cp_full < Cp1Limit) begin
            b[0] = cp_full[7:0]; n = 2'd1;
          end else if (cp_full < Cp2Limit) begin
            b[0] = Utf8Lead2 | {3'b000, cp_full[10:6]};
            b[1] = Utf8Cont | (cp_full[7:0] & Utf8Mask6);
            n    = 2'd2;
          end else begin
            b[0] = Utf8Lead3 | {4'h0, cp_full[15:12]};
            b[1] = Utf8Cont | (cp_full[13:6] & Utf8Mask6);
            b[2] = Utf8Cont | (cp_full[7:0] & Utf8Mask6);
            n    = 2'd3;
          end
        end else begin
          cp_d   = cp_full;
          mode_d = mode_q + 3'd1;
        end
      end
      default: begin
        // Expecting the opening quote (unused code acts the same)
        if (in_byte_i == "\"") begin
          mode_d = MBody; cp_d = '0; bad_d = 1'b0;
        end else begin
          status = StNoQuote;
          mode_d = MExpect; cp_d = '0; bad_d = 1'b0;
        end
      end
    endcase
  end

  // State update on each accepted beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MExpect;
      cp_q   <= '0;
      bad_q  <= 1'b0;
    end else if (accept_i) begin
      mode_q <= mode_d;
      cp_q   <= cp_d;
      bad_q  <= bad_d;
    end
  end

  assign res_o.bytes    = b;
  assign res_o.cnt      = (n == '0) ? 2'd1 : n;
  assign res_o.has_byte = (n != '0);
  assign res_o.status   = status;

endmodule

>>> src/jsu_outbuf.sv
// Result register and beat serializer: holds one decoded result and sends
// its 1 to 3 beats. Depends on jsu_pkg.
module jsu_outbuf import jsu_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  res_t               res_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic [ByteW-1:0]   out_byte_o,
  output logic               has_byte_o,
  output logic [StatusW-1:0] status_o,
  output logic               last_o,
  output logic               can_load_o
);

  res_t            res_q;
  logic            full_q, full_d;
  logic [CntW-1:0] idx_q, idx_d;
  logic            last_now, pop;

  assign last_now   = (idx_q == res_q.cnt - 2'd1);
  assign pop        = full_q && out_ready_i;
  assign can_load_o = !full_q || (pop && last_now);

  // Beat index and occupancy
  always_comb begin
    full_d = full_q;
    idx_d  = idx_q;
    if (pop) begin
      if (last_now) begin
        full_d = 1'b0;
        idx_d  = '0;
      end else begin
        idx_d = idx_q + 2'd1;
      end
    end
    if (load_i) begin
      full_d = 1'b1;
      idx_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      full_q <= full_d;
      idx_q  <= idx_d;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = full_q;
  assign out_byte_o  = (idx_q == 2'd3) ? '0 : res_q.bytes[idx_q];
  assign has_byte_o  = res_q.has_byte;
  assign status_o    = res_q.status;
  assign last_o      = last_now;

endmodule

>>> src/json_string_unescaper.sv
// JSON string unescaper top level: one JSON text byte per input beat,
// 1 to 3 decoded result beats out. The first result beat is offered in the
// cycle after the input beat is accepted. Throughput: one input byte per
// cycle while each byte yields one result beat and the output is not stalled;
// a 2- or 3-byte UTF-8 sequence holds the input on the single output port.
// Reset (asynchronous, active low) returns the scanner to waiting for a quote.
module json_string_unescaper import jsu_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  jsu_in_if.sink    in_i,
  jsu_out_if.source out_o
);

  logic accept;
  logic can_load;
  res_t res;

  assign in_i.ready = can_load;
  assign accept     = in_i.valid && can_load;

  // Scanner and decoder
  jsu_decode u_decode (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .in_byte_i (in_i.in_byte),
    .res_o     (res)
  );

  // Result register and serializer
  jsu_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept),
    .res_i       (res),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .out_byte_o  (out_o.out_byte),
    .has_byte_o  (out_o.has_byte),
    .status_o    (out_o.status),
    .last_o      (out_o.last),
    .can_load_o  (can_load)
  );

endmodule

>>> tb/unescape_monitor.sv
// Result monitor for the JSON string unescaper: watches both channels, decodes
// each accepted input beat into the expected result beats and compares them.
// Depends on jsu_pkg and the channel interfaces in jsu_if.
module unescape_monitor import jsu_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  jsu_in_if    in_mon,
  jsu_out_if   out_mon,
  output int   errors_o,
  output int   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [2:0] {
    ModeQuote, ModeBody, ModeEsc, ModeHex1, ModeHex2, ModeHex3, ModeHex4
  } scan_mode_e;

  typedef struct packed {
    logic [ByteW-1:0]   out_byte;
    logic               has_byte;
    logic [StatusW-1:0] status;
    logic               last;
  } beat_t;

  localparam logic [ByteW-1:0] ChNul   = 8'h00;
  localparam logic [ByteW-1:0] ChQuote = 8'h22;
  localparam logic [ByteW-1:0] ChBslash = 8'h5C;

  scan_mode_e  mode_q;
  logic [15:0] cp_q;
  logic        bad_q;
  beat_t       decoded_q[$];
  int          err_cnt;

  function automatic logic [3:0] hex_nibble(input logic [ByteW-1:0] c);
    if (c >= "0" && c <= "9") return 4'(c - "0");
    if (c >= "a" && c <= "f") return 4'(c - "a" + 8'd10);
    if (c >= "A" && c <= "F") return 4'(c - "A" + 8'd10);
    return 4'd0;
  endfunction

  task automatic clear_string();
    mode_q = ModeQuote;
    cp_q   = '0;
    bad_q  = 1'b0;
  endtask

  // Decode one text byte into 1 to 3 expected result beats
  task automatic decode_byte(input logic [ByteW-1:0] c);
    logic [ByteW-1:0]   dec [MaxBytes];
    int                 n;
    logic [StatusW-1:0] st;
    logic [15:0]        cp;
    beat_t              b;
    n  = 0;
    st = StRun;
    case (mode_q)
      ModeBody: begin
        if (c == ChNul) begin
          st = StUnterm;
          clear_string();
        end else if (c == ChQuote) begin
          st = bad_q ? StBadEsc : StDone;
          clear_string();
        end else if (c == ChBslash) begin
          mode_q = ModeEsc;
        end else begin
          dec[0] = c;
          n = 1;
        end
      end
      ModeEsc: begin
        mode_q = ModeBody;
        n = 1;
        case (c)
          ChNul: begin
            n  = 0;
            st = StUnterm;
            clear_string();
          end
          "n": dec[0] = 8'h0A;
          "r": dec[0] = 8'h0D;
          "t": dec[0] = 8'h09;
          "b": dec[0] = 8'h08;
          "f": dec[0] = 8'h0C;
          ChQuote, ChBslash, "/": dec[0] = c;
          "u": begin
            n      = 0;
            cp_q   = '0;
            mode_q = ModeHex1;
          end
          default: begin
            n     = 0;
            bad_q = 1'b1;
          end
        endcase
      end
      ModeHex1, ModeHex2, ModeHex3, ModeHex4: begin
        if (c == ChNul) begin
          st = StUnterm;
          clear_string();
        end else begin
          cp_q = {cp_q[11:0], hex_nibble(c)};
          if (mode_q == ModeHex4) begin
            cp = cp_q;
            // UTF-8 encode of the 16-bit code point
            if (cp < Cp1Limit) begin
              dec[0] = cp[7:0];
              n = 1;
            end else if (cp < Cp2Limit) begin
              dec[0] = Utf8Lead2 | 8'(cp >> 6);
              dec[1] = Utf8Cont | (cp[7:0] & Utf8Mask6);
              n = 2;
            end else begin
              dec[0] = Utf8Lead3 | 8'(cp >> 12);
              dec[1] = Utf8Cont | (8'(cp >> 6) & Utf8Mask6);
              dec[2] = Utf8Cont | (cp[7:0] & Utf8Mask6);
              n = 3;
            end
            cp_q   = '0;
            mode_q = ModeBody;
          end else begin
            mode_q = scan_mode_e'(mode_q + 3'd1);
          end
        end
      end
      default: begin
        if (c == ChQuote) begin
          mode_q = ModeBody;
          cp_q   = '0;
          bad_q  = 1'b0;
        end else begin
          st = StNoQuote;
          clear_string();
        end
      end
    endcase
    if (n == 0) begin
      b = '{out_byte: '0, has_byte: 1'b0, status: st, last: 1'b1};
      decoded_q.push_back(b);
    end else begin
      for (int k = 0; k < n; k++) begin
        b = '{out_byte: dec[k], has_byte: 1'b1, status: st, last: (k == n - 1)};
        decoded_q.push_back(b);
      end
    end
  endtask

  // Sample both channels at each rising edge
  always @(posedge clk_i or negedge rst_ni) begin : watch
    beat_t got;
    beat_t want;
    if (!rst_ni) begin
      clear_string();
      decoded_q.delete();
      err_cnt = 0;
      errors_o  <= 0;
      pending_o <= 0;
    end else begin
      if (in_mon.valid && in_mon.ready) decode_byte(in_mon.in_byte);
      if (out_mon.valid && out_mon.ready) begin
        got = '{out_byte: out_mon.out_byte, has_byte: out_mon.has_byte,
                status: out_mon.status, last: out_mon.last};
        if (decoded_q.size() == 0) begin
          $display("%0t: result beat with none expected: byte %h has %b status %0d last %b",
                   $realtime, got.out_byte, got.has_byte, got.status, got.last);
          err_cnt++;
        end else begin
          want = decoded_q.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch expected byte %h has %b status %0d last %b, got byte %h has %b status %0d last %b",
                     $realtime, want.out_byte, want.has_byte, want.status, want.last,
                     got.out_byte, got.has_byte, got.status, got.last);
            err_cnt++;
          end
        end
      end
      errors_o  <= err_cnt;
      pending_o <= decoded_q.size();
    end
  end

endmodule

>>> tb/testbench.sv
// Top of the JSON string unescaper testbench: clock, reset, text stimulus and
// receiver stalls; verdict from the result monitor's counters.
// Depends on jsu_pkg, jsu_if, json_string_unescaper and unescape_monitor.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic hold_on;
  logic text_done;
  int   errors;
  int   pending;

  jsu_in_if  in_if ();
  jsu_out_if out_if ();

  json_string_unescaper uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  unescape_monitor result_mon (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_mon    (in_if),
    .out_mon   (out_if),
    .errors_o  (errors),
    .pending_o (pending)
  );

  always #6 clk_i = ~clk_i;

  // Sender: build the text, then offer it in bursts with random gaps
  initial begin : sender
    logic [7:0] text_q[$];
    string      esc_set;
    string      hex_set;
    logic [7:0] b;
    int         n_el;
    int         kind;
    int         idx;
    int         burst_cnt;
    int         gap_cnt;
    int         range_sel;
    esc_set = "nrtbf\"\\/";
    hex_set = "0123456789abcdefABCDEF";
    in_if.valid   <= 1'b0;
    in_if.in_byte <= '0;
    text_done = 1'b0;

    // Directed text: missing quote, extremes, escapes, UTF-8 widths, errors
    text_q = '{"x", 8'h00, "\"", 8'hFF, 8'h01, "\\", "n", "\\", "q",
               "\\", "u", "0", "0", "0", "0",
               "\\", "u", "F", "f", "f", "F",
               "\\", "u", "0", "7", "g", "\"",
               "\"", "\"", "\\", 8'h00};

    // Random text: mostly well-formed strings, some noise and truncation
    while (text_q.size() < 360) begin
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 3)) text_q.push_back(8'($urandom_range(0, 255)));
      end else begin
        text_q.push_back("\"");
        n_el = $urandom_range(0, 8);
        for (int k = 0; k < n_el; k++) begin
          kind = $urandom_range(0, 9);
          if (kind <= 3) begin
            do b = 8'($urandom_range(1, 255)); while (b == "\"" || b == "\\");
            text_q.push_back(b);
          end else if (kind <= 5) begin
            text_q.push_back("\\");
            text_q.push_back(esc_set[$urandom_range(0, esc_set.len() - 1)]);
          end else if (kind <= 8) begin
            text_q.push_back("\\");
            text_q.push_back("u");
            range_sel = $urandom_range(0, 2);
            for (int d = 0; d < 4; d++) begin
              if ($urandom_range(0, 9) == 0) b = 8'($urandom_range(1, 255));
              else if (range_sel == 0 && d < 2) b = "0";
              else if (range_sel == 1 && d == 0) b = "0";
              else if (range_sel == 1 && d == 1) b = hex_set[$urandom_range(0, 7)];
              else b = hex_set[$urandom_range(0, hex_set.len() - 1)];
              text_q.push_back(b);
            end
          end else begin
            text_q.push_back("\\");
            text_q.push_back(8'($urandom_range(1, 255)));
          end
        end
        // Close normally, or cut off by a zero byte at some point
        if ($urandom_range(0, 9) != 0) begin
          text_q.push_back("\"");
        end else begin
          kind = $urandom_range(0, 2);
          if (kind >= 1) text_q.push_back("\\");
          if (kind == 2) begin
            text_q.push_back("u");
            repeat ($urandom_range(0, 3))
              text_q.push_back(hex_set[$urandom_range(0, hex_set.len() - 1)]);
          end
          text_q.push_back(8'h00);
        end
      end
    end

    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    idx = 0;
    burst_cnt = $urandom_range(1, 40);
    gap_cnt = 0;
    while (idx < text_q.size()) begin
      if (gap_cnt > 0 && !hold_on) begin
        in_if.valid <= 1'b0;
        gap_cnt--;
        @(posedge clk_i);
      end else begin
        in_if.valid   <= 1'b1;
        in_if.in_byte <= text_q[idx];
        @(posedge clk_i);
        while (!in_if.ready) @(posedge clk_i);
        idx++;
        if (burst_cnt > 0) begin
          burst_cnt--;
        end else begin
          burst_cnt = $urandom_range(1, 40);
          gap_cnt = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
    in_if.valid <= 1'b0;
    text_done = 1'b1;
  end

  // Receiver: stall pattern in segments, plus one long hold-off
  initial begin : receiver
    int cyc;
    int seg;
    int pat;
    out_if.ready <= 1'b0;
    hold_on <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    cyc = 0;
    seg = 0;
    pat = 0;
    forever begin
      if (cyc == 150) begin
        hold_on      <= 1'b1;
        out_if.ready <= 1'b0;
        repeat (200) @(posedge clk_i);
        hold_on <= 1'b0;
        cyc += 200;
      end
      if (seg == 0) begin
        seg = $urandom_range(10, 60);
        pat = $urandom_range(0, 3);
      end
      case (pat)
        0:       out_if.ready <= 1'b1;
        1:       out_if.ready <= 1'($urandom_range(0, 1));
        2:       out_if.ready <= ($urandom_range(0, 3) == 0);
        default: out_if.ready <= (cyc % 3 != 0);
      endcase
      seg--;
      cyc++;
      @(posedge clk_i);
    end
  end

  // Reset, drain and verdict
  initial begin : verdict
    rst_ni <= 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (text_done === 1'b1);
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #5ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule
